// ===== rtl/tcl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tile cell locator package
// Shared constants, codes and types for the tile cell locator.
// ----------------------------------------------------------------------------
package tcl_pkg;

   localparam int MaxLevels = 32;
   localparam int LevelBits = 5;
   localparam int CountBits = 6;
   localparam int SideBits  = 13;
   localparam int DataBits  = 64;
   localparam int ResBits   = 63;
   localparam int WideBits  = 77;

   localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
   localparam logic [2:0] REG_TILE_WIDTH  = 3'd2;
   localparam logic [2:0] REG_TILE_HEIGHT = 3'd3;
   localparam logic [2:0] REG_LEVEL_COUNT = 3'd4;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOCATE = 1'b1;

   localparam logic [1:0] STATUS_FOUND     = 2'd0;
   localparam logic [1:0] STATUS_NO_LEVEL  = 2'd1;
   localparam logic [1:0] STATUS_MISALIGN  = 2'd2;

   typedef struct packed {
      logic            start;
      logic [63:0]     num;
      logic [63:0]     den;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [63:0]     quo;
      logic [63:0]     rem;
   } div_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/tcl_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tile cell locator divider
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit unsigned.
// ----------------------------------------------------------------------------
module tcl_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tcl_pkg::div_req_type req,
   output tcl_pkg::div_rsp_type      rsp
);

   logic [63:0] quo_ff, quo_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[63:0], quo_ff[63]};
      diff    = trial - {1'b0, den_ff};
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[64]) begin
            rem_in = diff;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff[63:0];

endmodule
`default_nettype wire

// ===== rtl/tile_cell_locator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tile cell locator
// Maps a bounding box to a tile cell of a multi-level tile grid.
// ----------------------------------------------------------------------------
// A load word writes the level table while busy is low, and busy stays low. A
// locate word keeps busy high through five divisions in one shared radix-2
// divider (the box resolution per side, the tolerance, then the column and the
// row), a search of the levels in turn, the read of the matched entry in
// ST_SNAP and ST_PREP, and a last state that shows the result. A locate word
// that matches no level skips the column and row divisions. Busy is also high
// during reset. The one result word is shown with rsp_valid for a single cycle
// and must be taken then, since the receiver cannot stall.
module tile_cell_locator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [4:0]  req_level_index,
   input  wire logic [62:0] req_level_resolution,
   input  wire logic [63:0] req_min_x,
   input  wire logic [63:0] req_min_y,
   input  wire logic [63:0] req_max_x,
   input  wire logic [63:0] req_max_y,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_tile_column,
   output logic [31:0]      rsp_tile_row,
   output logic [4:0]       rsp_zoom_level,
   output logic [62:0]      rsp_snapped_resolution,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_DIVX  = 11'b00000000010,
      ST_DIVY  = 11'b00000000100,
      ST_DIVT  = 11'b00000001000,
      ST_SRCH  = 11'b00000010000,
      ST_SNAP  = 11'b00000100000,
      ST_PREP  = 11'b00001000000,
      ST_DIVC  = 11'b00010000000,
      ST_DIVR  = 11'b00100000000,
      ST_DONE  = 11'b01000000000,
      ST_CHKR  = 11'b10000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] origin_x_ff, origin_y_ff;
   logic [12:0] tile_width_ff, tile_height_ff;
   logic [5:0]  level_count_ff;
   logic [62:0] table_mem [tcl_pkg::MaxLevels];
   logic [62:0] rd_ff;
   logic [4:0]  rd_addr;

   logic [63:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic [63:0] res_ff, res_in;
   logic [63:0] tol_ff, tol_in;
   logic [5:0]  idx_ff, idx_in;
   logic [5:0]  cnt_lim;
   logic [4:0]  lvl_ff, lvl_in;
   logic        dstart_ff, dstart_in;
   logic        cneg_ff, cneg_in;
   logic [63:0] cnum_ff, cnum_in;
   logic [76:0] dwide_ff, dwide_in;
   logic [31:0] col_ff, col_in;
   logic        bad_ff, bad_in;
   logic        valid_ff, valid_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] ocol_ff, ocol_in, orow_ff, orow_in;
   logic [4:0]  olvl_ff, olvl_in;
   logic [62:0] ores_ff, ores_in;

   tcl_pkg::div_req_type dreq;
   tcl_pkg::div_rsp_type drsp;

   logic [12:0] tw, th, maxside;
   logic [63:0] dnum, dden;
   logic [63:0] lvdiff;
   logic [76:0] d_v;
   logic [64:0] twice;
   logic [63:0] q1;
   logic [76:0] err;
   logic        c_ok;
   logic [31:0] c_idx;

   assign tw      = (tile_width_ff == '0)  ? 13'd1 : tile_width_ff;
   assign th      = (tile_height_ff == '0) ? 13'd1 : tile_height_ff;
   assign maxside = (tw > th) ? tw : th;
   assign cnt_lim = (level_count_ff > 6'd32) ? 6'd32 : level_count_ff;

   tcl_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   always_comb begin
      dnum = 64'd0;
      dden = 64'd1;
      unique case (state_ff)
         ST_DIVX: begin
            dnum = max_x_ff - min_x_ff;
            dden = {51'd0, tw};
         end
         ST_DIVY: begin
            dnum = max_y_ff - min_y_ff;
            dden = {51'd0, th};
         end
         ST_DIVT: begin
            dnum = res_ff;
            dden = {51'd0, maxside};
         end
         ST_DIVC, ST_DIVR: begin
            dnum = cnum_ff;
            dden = dwide_ff[63:0];
         end
         default: begin
         end
      endcase
   end

   assign dreq.start = dstart_ff;
   assign dreq.num   = dnum;
   assign dreq.den   = dden;

   assign rd_addr = (state_in == ST_SRCH) ? idx_in[4:0] : lvl_ff;

   always_ff @(posedge clock) begin
      rd_ff <= table_mem[rd_addr];
      if (start && !busy && req_op == tcl_pkg::OP_LOAD) begin
         table_mem[req_level_index] <= req_level_resolution;
      end
   end

   assign lvdiff = ({1'b0, rd_ff} > res_ff) ? ({1'b0, rd_ff} - res_ff)
                                            : (res_ff - {1'b0, rd_ff});

   // Cell index check for the finished division of the column or row.
   always_comb begin
      d_v    = dwide_ff;
      twice  = {drsp.rem, 1'b0};
      q1     = drsp.quo;
      err    = {13'd0, drsp.rem};
      if (d_v[76:64] != '0) begin
         q1  = 64'd0;
         err = {13'd0, cnum_ff};
         twice = {cnum_ff, 1'b0};
      end
      if (!(d_v > {12'd0, twice})) begin
         q1  = q1 + 64'd1;
         err = d_v - {13'd0, twice[64:1]};
      end
      c_ok = !(err > {13'd0, res_ff});
      if (cneg_ff ? (q1 > 64'h80000000) : (q1 > 64'h7FFFFFFF)) begin
         c_ok = 1'b0;
      end
      c_idx = cneg_ff ? (32'd0 - q1[31:0]) : q1[31:0];
   end

   always_comb begin
      state_in  = state_ff;
      res_in    = res_ff;
      tol_in    = tol_ff;
      idx_in    = idx_ff;
      lvl_in    = lvl_ff;
      dstart_in = 1'b0;
      cneg_in   = cneg_ff;
      cnum_in   = cnum_ff;
      dwide_in  = dwide_ff;
      col_in    = col_ff;
      bad_in    = bad_ff;
      valid_in  = 1'b0;
      status_in = status_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;
      olvl_in   = olvl_ff;
      ores_in   = ores_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && req_op == tcl_pkg::OP_LOCATE) begin
               state_in  = ST_DIVX;
               dstart_in = 1'b1;
               res_in    = 64'd0;
            end
         end
         ST_DIVX: begin
            if (drsp.done) begin
               if ($signed(max_x_ff) > $signed(min_x_ff)) begin
                  res_in = drsp.quo;
               end
               state_in  = ST_DIVY;
               dstart_in = 1'b1;
            end
         end
         ST_DIVY: begin
            if (drsp.done) begin
               if ($signed(max_y_ff) > $signed(min_y_ff) && drsp.quo > res_ff) begin
                  res_in = drsp.quo;
               end
               state_in  = ST_DIVT;
               dstart_in = 1'b1;
            end
         end
         ST_DIVT: begin
            if (drsp.done) begin
               tol_in = drsp.quo;
               idx_in = 6'd0;
               if (res_ff == 64'd0 || cnt_lim == 6'd0) begin
                  status_in = tcl_pkg::STATUS_NO_LEVEL;
                  state_in  = ST_DONE;
               end else begin
                  state_in  = ST_SRCH;
               end
            end
         end
         ST_SRCH: begin
            // rd_ff holds the entry at idx_ff.
            if (lvdiff < tol_ff) begin
               lvl_in   = idx_ff[4:0];
               state_in = ST_SNAP;
            end else if (idx_ff + 6'd1 >= cnt_lim) begin
               status_in = tcl_pkg::STATUS_NO_LEVEL;
               state_in  = ST_DONE;
            end else begin
               idx_in = idx_ff + 6'd1;
            end
         end
         ST_SNAP: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            res_in    = {1'b0, rd_ff};
            ores_in   = rd_ff;
            olvl_in   = lvl_ff;
            cneg_in   = $signed(origin_x_ff) > $signed(min_x_ff);
            cnum_in   = cneg_in ? (origin_x_ff - min_x_ff) : (min_x_ff - origin_x_ff);
            dwide_in  = {1'b0, rd_ff} * {51'd0, tw};
            dstart_in = 1'b1;
            bad_in    = 1'b0;
            state_in  = ST_DIVC;
         end
         ST_DIVC: begin
            if (drsp.done) begin
               bad_in    = !c_ok;
               col_in    = c_idx;
               cneg_in   = $signed(origin_y_ff) > $signed(min_y_ff);
               cnum_in   = cneg_in ? (origin_y_ff - min_y_ff) : (min_y_ff - origin_y_ff);
               dwide_in  = res_ff * {51'd0, th};
               dstart_in = 1'b1;
               state_in  = ST_DIVR;
            end
         end
         ST_DIVR: begin
            if (drsp.done) begin
               if (bad_ff || !c_ok) begin
                  status_in = tcl_pkg::STATUS_MISALIGN;
                  ocol_in   = 32'd0;
                  orow_in   = 32'd0;
               end else begin
                  status_in = tcl_pkg::STATUS_FOUND;
                  ocol_in   = col_ff;
                  orow_in   = c_idx;
               end
               valid_in = 1'b1;
               state_in = ST_CHKR;
            end
         end
         ST_DONE: begin
            ocol_in  = 32'd0;
            orow_in  = 32'd0;
            olvl_in  = 5'd0;
            ores_in  = 63'd0;
            valid_in = 1'b1;
            state_in = ST_CHKR;
         end
         ST_CHKR: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         min_x_ff <= req_min_x;
         min_y_ff <= req_min_y;
         max_x_ff <= req_max_x;
         max_y_ff <= req_max_y;
      end
      res_ff    <= res_in;
      tol_ff    <= tol_in;
      idx_ff    <= idx_in;
      lvl_ff    <= lvl_in;
      cneg_ff   <= cneg_in;
      cnum_ff   <= cnum_in;
      dwide_ff  <= dwide_in;
      col_ff    <= col_in;
      bad_ff    <= bad_in;
      status_ff <= status_in;
      ocol_ff   <= ocol_in;
      orow_ff   <= orow_in;
      olvl_ff   <= olvl_in;
      ores_ff   <= ores_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         dstart_ff      <= 1'b0;
         valid_ff       <= 1'b0;
         origin_x_ff    <= 64'd0;
         origin_y_ff    <= 64'd0;
         tile_width_ff  <= 13'd256;
         tile_height_ff <= 13'd256;
         level_count_ff <= 6'd1;
      end else begin
         state_ff  <= state_in;
         dstart_ff <= dstart_in;
         valid_ff  <= valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               tcl_pkg::REG_ORIGIN_X:    origin_x_ff    <= csr_data;
               tcl_pkg::REG_ORIGIN_Y:    origin_y_ff    <= csr_data;
               tcl_pkg::REG_TILE_WIDTH:  tile_width_ff  <= csr_data[12:0];
               tcl_pkg::REG_TILE_HEIGHT: tile_height_ff <= csr_data[12:0];
               tcl_pkg::REG_LEVEL_COUNT: level_count_ff <= csr_data[5:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign busy                   = (state_ff != ST_IDLE) || reset;
   assign csr_ready              = 1'b1;
   assign rsp_valid              = valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_tile_column        = ocol_ff;
   assign rsp_tile_row           = orow_ff;
   assign rsp_zoom_level         = olvl_ff;
   assign rsp_snapped_resolution = ores_ff;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Tile cell locator testbench
// Loads the level table, sweeps the grid registers through several settings
// and sends directed and random locate words. An in-bench model predicts each
// result word, and a checker compares every strobed word with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] column;
      logic [31:0] row;
      logic [4:0]  zoom;
      logic [62:0] res;
   } cell_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_op = tcl_pkg::OP_LOAD;
   logic [4:0]  req_level_index = '0;
   logic [62:0] req_level_resolution = '0;
   logic [63:0] req_min_x = '0;
   logic [63:0] req_min_y = '0;
   logic [63:0] req_max_x = '0;
   logic [63:0] req_max_y = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_tile_column;
   logic [31:0] rsp_tile_row;
   logic [4:0]  rsp_zoom_level;
   logic [62:0] rsp_snapped_resolution;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [63:0] grid_origin_x;
   logic [63:0] grid_origin_y;
   logic [12:0] grid_tile_w;
   logic [12:0] grid_tile_h;
   logic [5:0]  grid_levels;
   logic [62:0] level_res [tcl_pkg::MaxLevels];

   cell_word_type cells_due[$];
   int unsigned mismatches = 0;
   int unsigned words_seen = 0;
   int unsigned status_seen [3] = '{0, 0, 0};
   int unsigned locates_sent = 0;
   int unsigned loads_sent = 0;
   longint unsigned cycles = 0;
   bit          idle_enable = 1'b1;

   tile_cell_locator dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] side_res(logic [63:0] lo, logic [63:0] hi,
                                            logic [63:0] side);
      if ($signed(hi) > $signed(lo)) return (hi - lo) / side;
      return 64'd0;
   endfunction

   function automatic bit cell_index(input logic [63:0] pos, input logic [63:0] org,
                                     input logic [63:0] res, input logic [63:0] side,
                                     output logic [31:0] idx);
      bit           neg;
      logic [63:0]  n, q, r;
      logic [127:0] d, twice, err;
      neg = $signed(org) > $signed(pos);
      n = neg ? org - pos : pos - org;
      d = {64'd0, res} * {64'd0, side};
      idx = '0;
      if (d[127:64] != 0) begin
         q = 0;
         r = n;
      end else begin
         q = n / d[63:0];
         r = n % d[63:0];
      end
      twice = {63'd0, r, 1'b0};
      if (!(d > twice)) begin
         q = q + 1;
         err = d - {64'd0, r};
      end else begin
         err = {64'd0, r};
      end
      if (err > {64'd0, res}) return 1'b0;
      if (neg ? q > 64'h8000_0000 : q > 64'h7FFF_FFFF) return 1'b0;
      q = neg ? 64'd0 - q : q;
      idx = q[31:0];
      return 1'b1;
   endfunction

   function automatic cell_word_type locate_cell(logic [63:0] mnx, logic [63:0] mny,
                                                 logic [63:0] mxx, logic [63:0] mxy);
      cell_word_type w;
      logic [63:0] tw, th, res, tol, cnt, lv, diff, ms;
      logic [31:0] col, row;
      int          hit;
      w = '{status: tcl_pkg::STATUS_NO_LEVEL, default: '0};
      tw = (grid_tile_w == 0) ? 64'd1 : 64'(grid_tile_w);
      th = (grid_tile_h == 0) ? 64'd1 : 64'(grid_tile_h);
      res = side_res(mnx, mxx, tw);
      if (side_res(mny, mxy, th) > res) res = side_res(mny, mxy, th);
      if (res == 0) return w;
      ms = (tw > th) ? tw : th;
      tol = res / ms;
      cnt = (grid_levels > tcl_pkg::MaxLevels) ? tcl_pkg::MaxLevels : grid_levels;
      hit = -1;
      for (int i = 0; i < cnt && hit < 0; i++) begin
         lv = {1'b0, level_res[i]};
         diff = (lv > res) ? lv - res : res - lv;
         if (diff < tol) hit = i;
      end
      if (hit < 0) return w;
      lv = {1'b0, level_res[hit]};
      w.zoom = hit[4:0];
      w.res = lv[62:0];
      if (!cell_index(mnx, grid_origin_x, lv, tw, col) ||
          !cell_index(mny, grid_origin_y, lv, th, row)) begin
         w.status = tcl_pkg::STATUS_MISALIGN;
         return w;
      end
      w.status = tcl_pkg::STATUS_FOUND;
      w.column = col;
      w.row = row;
      return w;
   endfunction

   task automatic send_word(logic op, logic [4:0] li, logic [62:0] lres,
                            logic [63:0] mnx, logic [63:0] mny,
                            logic [63:0] mxx, logic [63:0] mxy);
      if (idle_enable && $urandom_range(0, 99) < 20) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_level_index <= li;
      req_level_resolution <= lres;
      req_min_x <= mnx;
      req_min_y <= mny;
      req_max_x <= mxx;
      req_max_y <= mxy;
      do @(posedge clock); while (busy !== 1'b0);
      if (op == tcl_pkg::OP_LOAD) begin
         level_res[li] = lres;
         loads_sent++;
      end else begin
         cells_due.push_back(locate_cell(mnx, mny, mxx, mxy));
         locates_sent++;
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (cells_due.size() != 0) @(posedge clock);
      repeat (450) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         tcl_pkg::REG_ORIGIN_X:    grid_origin_x = value;
         tcl_pkg::REG_ORIGIN_Y:    grid_origin_y = value;
         tcl_pkg::REG_TILE_WIDTH:  grid_tile_w = value[12:0];
         tcl_pkg::REG_TILE_HEIGHT: grid_tile_h = value[12:0];
         tcl_pkg::REG_LEVEL_COUNT: grid_levels = value[5:0];
         default: ;
      endcase
   endtask

   task automatic set_grid(logic [63:0] ox, logic [63:0] oy, logic [12:0] tw,
                           logic [12:0] th, logic [5:0] cnt);
      drain();
      write_reg(tcl_pkg::REG_ORIGIN_X, ox);
      write_reg(tcl_pkg::REG_ORIGIN_Y, oy);
      write_reg(tcl_pkg::REG_TILE_WIDTH, {51'd0, tw});
      write_reg(tcl_pkg::REG_TILE_HEIGHT, {51'd0, th});
      write_reg(tcl_pkg::REG_LEVEL_COUNT, {58'd0, cnt});
   endtask

   task automatic load_level(int i, bit noisy);
      logic [62:0] v;
      v = noisy ? rand64() : ((63'd1 << (40 - i)) | 63'(rand64() & ((64'd1 << (30 - i)) - 1)));
      send_word(tcl_pkg::OP_LOAD, i[4:0], v, '0, '0, '0, '0);
   endtask

   // A box whose resolution equals one level, placed a random number of cells
   // from the origin, with a corner offset that is usually within one pixel.
   task automatic send_aligned_box(bit wild);
      logic [63:0] tw, th, r, dx, dy, kx, ky, ox, oy, mnx, mny;
      int          cnt, lvl;
      cnt = (grid_levels > tcl_pkg::MaxLevels) ? tcl_pkg::MaxLevels : grid_levels;
      if (cnt == 0) begin
         send_word(tcl_pkg::OP_LOCATE, '0, '0, rand64(), rand64(), rand64(), rand64());
         return;
      end
      tw = (grid_tile_w == 0) ? 64'd1 : 64'(grid_tile_w);
      th = (grid_tile_h == 0) ? 64'd1 : 64'(grid_tile_h);
      lvl = $urandom_range(0, cnt - 1);
      r = {1'b0, level_res[lvl]};
      dx = r * tw;
      dy = r * th;
      kx = wild ? 64'(32'h7FFF_FF00 + $urandom_range(0, 511)) : 64'($urandom_range(0, 2000));
      ky = 64'($urandom_range(0, 2000));
      if ($urandom_range(0, 1)) kx = -kx;
      if ($urandom_range(0, 1)) ky = -ky;
      ox = ($urandom_range(0, 3) == 0) ? rand64() % (dx + 1) : rand64() % (r + 1);
      oy = rand64() % (r + 2);
      if ($urandom_range(0, 1)) ox = -ox;
      if ($urandom_range(0, 1)) oy = -oy;
      mnx = grid_origin_x + kx * dx + ox;
      mny = grid_origin_y + ky * dy + oy;
      send_word(tcl_pkg::OP_LOCATE, '0, '0, mnx, mny, mnx + dx + $urandom_range(0, tw - 1),
                mny + dy - $urandom_range(0, 1) * r);
   endtask

   task automatic test_table_load();
      for (int i = 0; i < tcl_pkg::MaxLevels; i++) load_level(i, 1'b0);
      repeat (4) send_aligned_box(1'b0);
   endtask

   task automatic test_directed();
      logic [63:0] maxp, minp;
      maxp = 64'h7FFF_FFFF_FFFF_FFFF;
      minp = 64'h8000_0000_0000_0000;
      set_grid('0, '0, 13'd16, 13'd8, 6'd32);
      send_word(tcl_pkg::OP_LOCATE, '0, '0, 64'd5, 64'd5, 64'd5, 64'd5);
      send_word(tcl_pkg::OP_LOCATE, '0, '0, maxp, maxp, minp, minp);
      send_word(tcl_pkg::OP_LOCATE, '0, '0, minp, minp, maxp, maxp);
      send_word(tcl_pkg::OP_LOCATE, '0, '0, 64'd0, 64'd0, 64'd1, 64'd1);
      send_aligned_box(1'b0);
      send_aligned_box(1'b1);
      send_word(tcl_pkg::OP_LOAD, 5'd31, 63'h7FFF_FFFF_FFFF_FFFF, '0, '0, '0, '0);
      send_word(tcl_pkg::OP_LOCATE, '0, '0, minp, 64'd0, maxp, 64'd1);
      load_level(31, 1'b0);
      set_grid(maxp, minp, 13'd0, 13'd8191, 6'd63);
      write_reg(3'd5, rand64());
      write_reg(3'd7, rand64());
      send_aligned_box(1'b0);
      send_aligned_box(1'b0);
      send_word(tcl_pkg::OP_LOCATE, '0, '0, minp, minp, maxp, maxp);
      set_grid('0, '0, 13'd4096, 13'd1, 6'd0);
      send_aligned_box(1'b0);
      send_word(tcl_pkg::OP_LOCATE, '0, '0, 64'd0, 64'd0, maxp, maxp);
   endtask

   task automatic test_random_phases();
      logic [12:0] tw, th;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin tw = 13'd256; th = 13'd256; end
            1: begin tw = 13'd1; th = 13'd1; end
            2: begin tw = 13'd4096; th = 13'd4096; end
            default: begin
               tw = 13'($urandom_range(1, 4096));
               th = 13'($urandom_range(1, 4096));
            end
         endcase
         set_grid((p < 2) ? 64'd0 : rand64() >> 4, (p < 2) ? 64'd0 : -(rand64() >> 4),
                  tw, th, (p == 3) ? 6'd1 : 6'($urandom_range(2, 40)));
         idle_enable = (p != 2);
         for (int n = 0; n < 240; n++) begin
            case ($urandom_range(0, 19))
               0, 1: load_level($urandom_range(0, tcl_pkg::MaxLevels - 1), 1'b0);
               2: load_level($urandom_range(0, tcl_pkg::MaxLevels - 1), 1'b1);
               3, 4, 5: send_word(tcl_pkg::OP_LOCATE, '0, '0, rand64(), rand64(),
                                  rand64(), rand64());
               6: send_aligned_box(1'b1);
               default: send_aligned_box(1'b0);
            endcase
            if (n == 120) drain();
         end
         idle_enable = 1'b1;
         for (int i = 0; i < tcl_pkg::MaxLevels; i++)
            if (level_res[i] > 63'h0000_FFFF_FFFF_FFFF) load_level(i, 1'b0);
      end
   endtask

   always @(posedge clock) begin
      cell_word_type exp_w, got_w;
      cycles <= cycles + 1;
      if (!reset && rsp_valid === 1'b1) begin
         got_w = '{rsp_status, rsp_tile_column, rsp_tile_row, rsp_zoom_level,
                   rsp_snapped_resolution};
         words_seen++;
         if (rsp_status < 3) status_seen[rsp_status]++;
         if (cells_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", got_w);
         end else begin
            exp_w = cells_due.pop_front();
            if (got_w !== exp_w) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", exp_w, got_w);
            end
         end
      end
   end

   initial begin
      grid_origin_x = '0;
      grid_origin_y = '0;
      grid_tile_w = 13'd256;
      grid_tile_h = 13'd256;
      grid_levels = 6'd1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_load();
      test_directed();
      test_random_phases();
      drain();
      if (cells_due.size() != 0) mismatches++;
      $display("sent %0d load and %0d locate words over %0d cycles", loads_sent,
               locates_sent, cycles);
      $display("result words: %0d found, %0d no level, %0d misaligned", status_seen[0],
               status_seen[1], status_seen[2]);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      wait (cycles >= 64'd2_500_000);
      $display("tb: failure");
      $finish;
   end

endmodule
